// ===== rtl/rait_pkg.sv =====
// shared types and constants for the remote address id table
package rait_pkg;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int ID_W   = 8;
  localparam int IP_W   = 32;
  localparam int PORT_W = 16;
  localparam int ST_W   = 3;

  // widest slot index and port count over the supported table sizes (up to 8 by 8)
  localparam int SLOT_IDX_W = 3;
  localparam int CNT_W      = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 3'd0,
    ST_IP_CONFLICT = 3'd1,
    ST_PORT_KNOWN  = 3'd2,
    ST_ID_UNKNOWN  = 3'd3,
    ST_TABLE_FULL  = 3'd4,
    ST_PORTS_FULL  = 3'd5,
    ST_EMPTY_LIST  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ADD_CHK,
    S_ADD_SCAN,
    S_ADD_END,
    S_RESP,
    S_LIST_SEL,
    S_LIST_PORT
  } fsm_t;

  // update of the slot directory
  typedef struct packed {
    logic                  alloc;
    logic                  remove;
    logic                  inc;
    logic [SLOT_IDX_W-1:0] slot;
    logic [ID_W-1:0]       id;
  } dir_cmd_t;

  // search results of the slot directory
  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_slot;
    logic [CNT_W-1:0]      hit_cnt;
    logic                  free_avail;
    logic [SLOT_IDX_W-1:0] free_slot;
    logic                  sel_valid;
    logic [SLOT_IDX_W-1:0] sel_slot;
    logic [CNT_W-1:0]      sel_cnt;
    logic                  more_after;
    logic                  any_ports;
  } dir_look_t;

endpackage

// ===== rtl/rait_if.sv =====
// valid/ready channel interfaces for requests and results
interface rait_in_if import rait_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ID_W-1:0]   addr_id;
  logic [IP_W-1:0]   ipv4_addr;
  logic [PORT_W-1:0] port_num;

  modport source (output valid, opcode, addr_id, ipv4_addr, port_num, input ready);
  modport sink   (input valid, opcode, addr_id, ipv4_addr, port_num, output ready);
endinterface

interface rait_out_if import rait_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [IP_W-1:0]   dest_ip;
  logic [PORT_W-1:0] dest_port;
  logic              last;

  modport source (output valid, status, dest_ip, dest_port, last, input ready);
  modport sink   (input valid, status, dest_ip, dest_port, last, output ready);
endinterface

// ===== rtl/rait_ram.sv =====
// generic single write port, single read port ram with registered read
module rait_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/rait_dir.sv =====
// slot directory: valid bits, ids and port counts with parallel search
module rait_dir import rait_pkg::*; #(
  parameter int TABLE_ENTRIES   = 8,
  parameter int PORTS_PER_ENTRY = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ID_W-1:0]       look_id,
  input  logic [SLOT_IDX_W-1:0] look_rank,
  input  dir_cmd_t              cmd,
  output dir_look_t             look
);

  localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(PORTS_PER_ENTRY + 1);

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] valid_nxt;
  logic [ID_W-1:0]          id_r  [TABLE_ENTRIES];
  logic [CW-1:0]            cnt_r [TABLE_ENTRIES];
  logic [SLOT_IDX_W-1:0]    rank  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [SW-1:0]            cmd_slot;

  assign cmd_slot = cmd.slot[SW-1:0];

  // rank of each slot: number of valid slots holding a smaller id
  always_comb begin
    for (int j = 0; j < TABLE_ENTRIES; j++) begin
      rank[j] = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (valid_r[i] && (id_r[i] < id_r[j])) begin
          rank[j] = SLOT_IDX_W'(rank[j] + 1'b1);
        end
      end
    end
  end

  // id match, lowest free slot, slot at the requested rank
  always_comb begin
    look = '0;
    for (int s = TABLE_ENTRIES - 1; s >= 0; s--) begin
      hit_vec[s] = valid_r[s] && (id_r[s] == look_id);
      if (hit_vec[s]) begin
        look.hit      = 1'b1;
        look.hit_slot = SLOT_IDX_W'(s);
        look.hit_cnt  = CNT_W'(cnt_r[s]);
      end
      if (!valid_r[s]) begin
        look.free_avail = 1'b1;
        look.free_slot  = SLOT_IDX_W'(s);
      end
      if (valid_r[s] && (cnt_r[s] != '0)) begin
        look.any_ports = 1'b1;
        if (rank[s] == look_rank) begin
          look.sel_valid = 1'b1;
          look.sel_slot  = SLOT_IDX_W'(s);
          look.sel_cnt   = CNT_W'(cnt_r[s]);
        end
        if (rank[s] > look_rank) begin
          look.more_after = 1'b1;
        end
      end
    end
  end

  // valid bit update
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.alloc) begin
      valid_nxt[cmd_slot] = 1'b1;
    end
    if (cmd.remove) begin
      valid_nxt[cmd_slot] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // id and port count per slot
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      id_r[cmd_slot]  <= cmd.id;
      cnt_r[cmd_slot] <= '0;
    end else if (cmd.inc) begin
      cnt_r[cmd_slot] <= CW'(cnt_r[cmd_slot] + 1'b1);
    end
  end

  // a valid id lives in one slot only
  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
    else $error("id found in more than one slot");

  // ports are only appended to a live slot
  assert property (@(posedge clk) disable iff (!rst_n) cmd.inc |-> valid_r[cmd_slot])
    else $error("port append to an empty slot");

endmodule

// ===== rtl/remote_addr_id_table.sv =====
// remote address id table: add, remove and list of (address, port) destinations
// remove, add of a new id and an empty list do a directory lookup and then give the result
// add to a known id looks up, compares the address, for a nonzero port compares each listed
// port in turn, then appends or flags a full list; list looks up, then per slot rank emits
// its destinations; the next transaction is taken once the final result sits in the output register
// reset clears the slot valid bits, the state and the output valid; the address and port rams are not cleared
module remote_addr_id_table import rait_pkg::*; #(
  parameter int TABLE_ENTRIES   = 8,
  parameter int PORTS_PER_ENTRY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  rait_in_if.sink     in_ch,
  rait_out_if.source  out_ch
);

  localparam int SW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW  = $clog2(PORTS_PER_ENTRY + 1);
  localparam int PD  = TABLE_ENTRIES * PORTS_PER_ENTRY;
  localparam int PAW = (PD > 1) ? $clog2(PD) : 1;

  fsm_t              state_r, state_nxt;
  op_t               op_r;
  logic [ID_W-1:0]   id_r;
  logic [IP_W-1:0]   ip_r;
  logic [PORT_W-1:0] port_r;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     pidx_r, pidx_nxt;
  logic [SW-1:0]     rank_r, rank_nxt;
  logic              last_slot_r, last_slot_nxt;
  status_t           st_r, st_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [IP_W-1:0]   out_ip_r;
  logic [PORT_W-1:0] out_port_r;
  logic              out_last_r;
  logic              out_free;
  logic              out_load;
  status_t           out_status_nxt;
  logic [IP_W-1:0]   out_ip_nxt;
  logic [PORT_W-1:0] out_port_nxt;
  logic              out_last_nxt;

  logic              in_acc;
  logic              pidx_fin;

  logic              ip_we;
  logic [SW-1:0]     ip_wr_addr;
  logic              ip_rd_en;
  logic [SW-1:0]     ip_rd_addr;
  logic [IP_W-1:0]   ip_rdata;

  logic              port_we;
  logic [PAW-1:0]    port_wr_addr;
  logic              port_rd_en;
  logic [SW-1:0]     rd_slot;
  logic [CW-1:0]     rd_idx;
  logic [PAW-1:0]    port_rd_addr;
  logic [PORT_W-1:0] port_rdata;

  dir_cmd_t          dir_cmd;
  dir_look_t         look;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign pidx_fin = (CW'(pidx_r + 1'b1) == cnt_r);

  assign port_rd_addr = PAW'(int'(rd_slot) * PORTS_PER_ENTRY + int'(rd_idx));
  assign port_wr_addr = PAW'(int'(slot_r) * PORTS_PER_ENTRY + int'(cnt_r));

  // slot directory
  rait_dir #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .PORTS_PER_ENTRY (PORTS_PER_ENTRY)
  ) u_dir (
    .clk       (clk),
    .rst_n     (rst_n),
    .look_id   (id_r),
    .look_rank (SLOT_IDX_W'(rank_r)),
    .cmd       (dir_cmd),
    .look      (look)
  );

  // address per slot
  rait_ram #(
    .WIDTH (IP_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ip_ram (
    .clk     (clk),
    .wr_en   (ip_we),
    .wr_addr (ip_wr_addr),
    .wr_data (ip_r),
    .rd_en   (ip_rd_en),
    .rd_addr (ip_rd_addr),
    .rd_data (ip_rdata)
  );

  // port lists, one row of ports per slot
  rait_ram #(
    .WIDTH (PORT_W),
    .DEPTH (PD)
  ) u_port_ram (
    .clk     (clk),
    .wr_en   (port_we),
    .wr_addr (port_wr_addr),
    .wr_data (port_r),
    .rd_en   (port_rd_en),
    .rd_addr (port_rd_addr),
    .rd_data (port_rdata)
  );

  // sequencer next state and outputs
  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    pidx_nxt       = pidx_r;
    rank_nxt       = rank_r;
    last_slot_nxt  = last_slot_r;
    st_nxt         = st_r;
    in_ch.ready    = 1'b0;
    out_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_ip_nxt     = '0;
    out_port_nxt   = '0;
    out_last_nxt   = 1'b1;
    ip_we          = 1'b0;
    ip_wr_addr     = '0;
    ip_rd_en       = 1'b0;
    ip_rd_addr     = '0;
    port_we        = 1'b0;
    port_rd_en     = 1'b0;
    rd_slot        = slot_r;
    rd_idx         = '0;
    dir_cmd        = '0;
    dir_cmd.id     = id_r;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if ((in_ch.opcode == OP_ADD) || (in_ch.opcode == OP_REMOVE) ||
              (in_ch.opcode == OP_LIST)) begin
            state_nxt = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        state_nxt = S_RESP;
        unique case (op_r)
          OP_ADD: begin
            if (look.hit) begin
              slot_nxt   = look.hit_slot[SW-1:0];
              cnt_nxt    = look.hit_cnt[CW-1:0];
              ip_rd_en   = 1'b1;
              ip_rd_addr = look.hit_slot[SW-1:0];
              state_nxt  = S_ADD_CHK;
            end else if (look.free_avail) begin
              dir_cmd.alloc = 1'b1;
              dir_cmd.slot  = look.free_slot;
              ip_we         = 1'b1;
              ip_wr_addr    = look.free_slot[SW-1:0];
              st_nxt        = ST_OK;
            end else begin
              st_nxt = ST_TABLE_FULL;
            end
          end
          OP_REMOVE: begin
            if (look.hit) begin
              dir_cmd.remove = 1'b1;
              dir_cmd.slot   = look.hit_slot;
              st_nxt         = ST_OK;
            end else begin
              st_nxt = ST_ID_UNKNOWN;
            end
          end
          OP_LIST: begin
            if (look.any_ports) begin
              rank_nxt  = '0;
              state_nxt = S_LIST_SEL;
            end else begin
              st_nxt = ST_EMPTY_LIST;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // address compare, then the port scan if a nonzero port is given and the slot has ports
      S_ADD_CHK: begin
        state_nxt = S_RESP;
        if (ip_rdata != ip_r) begin
          st_nxt = ST_IP_CONFLICT;
        end else if (port_r == '0) begin
          st_nxt = ST_OK;
        end else if (cnt_r == '0) begin
          state_nxt = S_ADD_END;
        end else begin
          port_rd_en = 1'b1;
          rd_idx     = '0;
          pidx_nxt   = '0;
          state_nxt  = S_ADD_SCAN;
        end
      end

      // one listed port compared per cycle
      S_ADD_SCAN: begin
        if (port_rdata == port_r) begin
          st_nxt    = ST_PORT_KNOWN;
          state_nxt = S_RESP;
        end else if (pidx_fin) begin
          state_nxt = S_ADD_END;
        end else begin
          pidx_nxt   = CW'(pidx_r + 1'b1);
          port_rd_en = 1'b1;
          rd_idx     = CW'(pidx_r + 1'b1);
        end
      end

      // append the new port or flag a full list
      S_ADD_END: begin
        state_nxt = S_RESP;
        if (cnt_r == CW'(PORTS_PER_ENTRY)) begin
          st_nxt = ST_PORTS_FULL;
        end else begin
          port_we      = 1'b1;
          dir_cmd.inc  = 1'b1;
          dir_cmd.slot = SLOT_IDX_W'(slot_r);
          st_nxt       = ST_OK;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = st_r;
          state_nxt      = S_IDLE;
        end
      end

      // find the slot at the current id rank that holds ports
      S_LIST_SEL: begin
        if (look.sel_valid) begin
          slot_nxt      = look.sel_slot[SW-1:0];
          cnt_nxt       = look.sel_cnt[CW-1:0];
          pidx_nxt      = '0;
          last_slot_nxt = !look.more_after;
          ip_rd_en      = 1'b1;
          ip_rd_addr    = look.sel_slot[SW-1:0];
          port_rd_en    = 1'b1;
          rd_slot       = look.sel_slot[SW-1:0];
          rd_idx        = '0;
          state_nxt     = S_LIST_PORT;
        end else begin
          rank_nxt = SW'(rank_r + 1'b1);
        end
      end

      // emit one destination per cycle while the output register is free
      S_LIST_PORT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = ST_OK;
          out_ip_nxt     = ip_rdata;
          out_port_nxt   = port_rdata;
          out_last_nxt   = last_slot_r && pidx_fin;
          if (pidx_fin) begin
            if (last_slot_r) begin
              state_nxt = S_IDLE;
            end else begin
              rank_nxt  = SW'(rank_r + 1'b1);
              state_nxt = S_LIST_SEL;
            end
          end else begin
            pidx_nxt   = CW'(pidx_r + 1'b1);
            port_rd_en = 1'b1;
            rd_idx     = CW'(pidx_r + 1'b1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // transaction fields and walk counters
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= op_t'(in_ch.opcode);
      id_r   <= in_ch.addr_id;
      ip_r   <= in_ch.ipv4_addr;
      port_r <= in_ch.port_num;
    end
    slot_r      <= slot_nxt;
    cnt_r       <= cnt_nxt;
    pidx_r      <= pidx_nxt;
    rank_r      <= rank_nxt;
    last_slot_r <= last_slot_nxt;
    st_r        <= st_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_ip_r     <= out_ip_nxt;
      out_port_r   <= out_port_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.dest_ip   = out_ip_r;
  assign out_ch.dest_port = out_port_r;
  assign out_ch.last      = out_last_r;

  // between transactions only a final result can be pending
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!out_valid_r || out_last_r))
    else $error("non-final result pending while idle");

  // a port is never appended past the end of its row
  assert property (@(posedge clk) disable iff (!rst_n)
    port_we |-> (cnt_r < CW'(PORTS_PER_ENTRY)))
    else $error("port append beyond row");

  // a new slot is taken only for an unknown id
  assert property (@(posedge clk) disable iff (!rst_n)
    dir_cmd.alloc |-> (!look.hit && look.free_avail))
    else $error("slot allocated for a known id or a full table");

endmodule

// ===== sim/remote_addr_id_table_tb.sv =====
`timescale 1ns / 1ps
// testbench for the remote address id table: directed and random requests against a scoreboard
module remote_addr_id_table_tb;
  import rait_pkg::*;

  localparam int TABLE_ENTRIES   = 8;
  localparam int PORTS_PER_ENTRY = 8;
  localparam int ID_SPAN         = 256;
  localparam int CLK_HALF        = 4;
  localparam int RANDOM_REQS     = 280;
  localparam int IDLE_PCT        = 22;
  localparam int STALL_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int POOL_IDS        = 12;
  localparam int POOL_PORTS      = 12;

  // opcode with no function, ignored by the block
  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [PORT_W-1:0] NO_PORT   = '0;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [IP_W-1:0]   dest_ip;
    logic [PORT_W-1:0] dest_port;
    logic              last;
  } dest_reply_t;

  // shadow copy of the address table and the replies it predicts
  class addr_table_scoreboard;
    bit                slot_used      [TABLE_ENTRIES];
    logic [ID_W-1:0]   slot_addr_id   [TABLE_ENTRIES];
    logic [IP_W-1:0]   slot_ipv4      [TABLE_ENTRIES];
    int                slot_nports    [TABLE_ENTRIES];
    logic [PORT_W-1:0] slot_port_list [TABLE_ENTRIES][PORTS_PER_ENTRY];
    dest_reply_t       pending_replies [$];
    int                mismatches;

    function int lookup(logic [ID_W-1:0] id);
      for (int s = 0; s < TABLE_ENTRIES; s++)
        if (slot_used[s] && slot_addr_id[s] == id) return s;
      return -1;
    endfunction

    function void push_reply(status_t st, logic [IP_W-1:0] ip, logic [PORT_W-1:0] port,
                             logic last);
      dest_reply_t r;
      r.status    = st;
      r.dest_ip   = ip;
      r.dest_port = port;
      r.last      = last;
      pending_replies = {pending_replies, r};
    endfunction

    // add: known id checks address and appends a port, unknown id takes the lowest free slot
    function status_t apply_add(logic [ID_W-1:0] id, logic [IP_W-1:0] ip,
                                logic [PORT_W-1:0] port);
      int s;
      int n;
      s = lookup(id);
      if (s >= 0) begin
        if (slot_ipv4[s] != ip) return ST_IP_CONFLICT;
        if (port == NO_PORT) return ST_OK;
        n = slot_nports[s];
        for (int p = 0; p < n; p++)
          if (slot_port_list[s][p] == port) return ST_PORT_KNOWN;
        if (n >= PORTS_PER_ENTRY) return ST_PORTS_FULL;
        slot_port_list[s][n] = port;
        slot_nports[s]       = n + 1;
        return ST_OK;
      end
      for (s = 0; s < TABLE_ENTRIES; s++) begin
        if (!slot_used[s]) begin
          slot_used[s]    = 1'b1;
          slot_addr_id[s] = id;
          slot_ipv4[s]    = ip;
          slot_nports[s]  = 0;
          return ST_OK;
        end
      end
      return ST_TABLE_FULL;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
      int s;
      int first_idx;
      case (op)
        OP_ADD: push_reply(apply_add(id, ip, port), '0, '0, 1'b1);
        OP_REMOVE: begin
          s = lookup(id);
          if (s >= 0) begin
            slot_used[s] = 1'b0;
            push_reply(ST_OK, '0, '0, 1'b1);
          end else begin
            push_reply(ST_ID_UNKNOWN, '0, '0, 1'b1);
          end
        end
        OP_LIST: begin
          // ascending id order, ports in insertion order
          first_idx = pending_replies.size();
          for (int v = 0; v < ID_SPAN; v++) begin
            s = lookup(ID_W'(v));
            if (s >= 0)
              for (int p = 0; p < slot_nports[s]; p++)
                push_reply(ST_OK, slot_ipv4[s], slot_port_list[s][p], 1'b0);
          end
          if (pending_replies.size() == first_idx)
            push_reply(ST_EMPTY_LIST, '0, '0, 1'b1);
          else
            pending_replies[pending_replies.size() - 1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_reply(logic [ST_W-1:0] status, logic [IP_W-1:0] ip,
                              logic [PORT_W-1:0] port, logic last);
      dest_reply_t exp_r;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d dest_ip %h dest_port %h last %b",
               status, ip, port, last);
        mismatches++;
        return;
      end
      exp_r = pending_replies.pop_front();
      if (status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, status);
        mismatches++;
      end
      if (ip !== exp_r.dest_ip) begin
        $error("dest_ip: expected %h, actual %h", exp_r.dest_ip, ip);
        mismatches++;
      end
      if (port !== exp_r.dest_port) begin
        $error("dest_port: expected %h, actual %h", exp_r.dest_port, port);
        mismatches++;
      end
      if (last !== exp_r.last) begin
        $error("last: expected %b, actual %b", exp_r.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle;
  int   stall_cycles = 0;

  addr_table_scoreboard sb;

  rait_in_if  in_ch();
  rait_out_if out_ch();

  remote_addr_id_table #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .PORTS_PER_ENTRY(PORTS_PER_ENTRY)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #CLK_HALF clk = ~clk;

  // result side backpressure
  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // monitor both channels, track cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_reply(out_ch.status, out_ch.dest_ip, out_ch.dest_port, out_ch.last);
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.opcode, in_ch.addr_id, in_ch.ipv4_addr, in_ch.port_num);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // watchdog
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // one request transaction, with an optional random gap first
  task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.addr_id   <= id;
    in_ch.ipv4_addr <= ip;
    in_ch.port_num  <= port;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off the sender until every predicted reply has arrived
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [ID_W-1:0]   id_pool   [POOL_IDS];
    logic [IP_W-1:0]   ip_pool   [POOL_IDS];
    logic [PORT_W-1:0] port_pool [POOL_PORTS];
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    int                pick;
    int                roll;

    sb = new();
    no_idle = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_ADD;
    in_ch.addr_id   <= '0;
    in_ch.ipv4_addr <= '0;
    in_ch.port_num  <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, unknown id, port rules, full port list, full table
    send_request(OP_LIST, '0, '0, NO_PORT);
    send_request(OP_REMOVE, 8'hFF, '0, NO_PORT);
    send_request(OP_ADD, 8'h00, 32'h0, 16'h0007);
    send_request(OP_LIST, '0, '0, NO_PORT);
    send_request(OP_ADD, 8'h00, 32'h0, NO_PORT);
    send_request(OP_ADD, 8'h00, 32'h0, 16'hFFFF);
    send_request(OP_ADD, 8'h00, 32'h0, 16'hFFFF);
    send_request(OP_ADD, 8'h00, 32'h1, 16'h0005);
    send_request(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 16'h0001);
    for (int p = 2; p <= PORTS_PER_ENTRY + 1; p++)
      send_request(OP_ADD, 8'hFF, 32'hFFFF_FFFF, PORT_W'(p));
    send_request(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 16'h8000);
    send_request(OP_LIST, '0, '0, NO_PORT);
    send_request(OP_UNUSED, 8'hAA, 32'h5555_AAAA, 16'hA5A5);
    send_request(OP_REMOVE, 8'h00, '0, NO_PORT);
    for (int k = 0; k < TABLE_ENTRIES; k++)
      send_request(OP_ADD, ID_W'(8'h10 + k), $urandom, PORT_W'(k + 1));
    send_request(OP_LIST, '0, '0, NO_PORT);

    // random: mostly adds and removes over a small id pool so entries fill up
    foreach (id_pool[i]) begin
      id_pool[i] = ID_W'($urandom);
      ip_pool[i] = $urandom;
    end
    foreach (port_pool[i]) port_pool[i] = PORT_W'($urandom_range(1, 65535));

    for (int i = 0; i < RANDOM_REQS; i++) begin
      no_idle = (i >= 100 && i < 170);
      if (i == 220) drain_replies();
      pick = $urandom_range(0, POOL_IDS - 1);
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        ip = ($urandom_range(0, 9) == 0) ? IP_W'($urandom) : ip_pool[pick];
        case ($urandom_range(0, 4))
          0:       port = NO_PORT;
          4:       port = PORT_W'($urandom);
          default: port = port_pool[$urandom_range(0, POOL_PORTS - 1)];
        endcase
        send_request(OP_ADD, id_pool[pick], ip, port);
      end else if (roll < 78) begin
        send_request(OP_REMOVE,
                     ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : id_pool[pick],
                     $urandom, PORT_W'($urandom));
      end else if (roll < 90) begin
        send_request(OP_LIST, ID_W'($urandom), $urandom, PORT_W'($urandom));
      end else if (roll < 96) begin
        send_request(OP_ADD, ID_W'($urandom), $urandom, PORT_W'($urandom));
      end else begin
        send_request(OP_UNUSED, ID_W'($urandom), $urandom, PORT_W'($urandom));
      end
    end

    // wrap up
    no_idle = 1'b0;
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
